// File: rtl/tes_pkg.sv
// Shared constants and codes for the task event scheduler.
// No dependencies; the scheduler, the bench checker and the testbench import this package.
package tes_pkg;

	localparam int NUM_TASKS  = 8;
	localparam int EVENT_BITS = 32;
	localparam int TASK_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// item kinds
	localparam logic [2:0] KIND_POST     = 3'd0;
	localparam logic [2:0] KIND_CLEAR    = 3'd1;
	localparam logic [2:0] KIND_SLEEP    = 3'd2;
	localparam logic [2:0] KIND_TICK     = 3'd3;
	localparam logic [2:0] KIND_DISPATCH = 3'd4;

	// result status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_TRD  = 6'b001000,
		ST_TCMP = 6'b010000,
		ST_PUSH = 6'b100000
	} state_t;

endpackage

// File: rtl/task_event_scheduler.sv
// Round-robin event-flag task scheduler. One item is taken at a time and gives one
// result item. Post, clear and dispatch pass through a read of the event-mask RAM,
// a modify and write back, and the result register; sleep skips the read; tick
// walks the wakeup-time RAM one slot at a time, reading and then comparing each
// slot. Unknown kinds and rejected post or clear go straight to the result. A finished
// result waits in the output register while the next item is accepted.
module task_event_scheduler
	import tes_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            kind,
	input  logic [4:0]            task_index,
	input  logic [4:0]            event_number,
	input  logic [31:0]           duration_ms,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  status,
	output logic                  dispatched,
	output logic [4:0]            dispatched_task,
	output logic [4:0]            dispatched_event,
	output logic                  no_event
);

	state_t state_q;

	logic [7:0]            reg_tasks_q;
	logic [NUM_TASKS-1:0]  pending_q;
	logic [NUM_TASKS-1:0]  sleeping_q;
	logic [NUM_TASKS-1:0]  ev_vld_q;
	logic [NUM_TASKS-1:0]  wk_vld_q;
	logic [TASK_W-1:0]     scan_q;
	logic [TASK_W-1:0]     running_q;
	logic [TASK_W-1:0]     cnt_q;

	logic [2:0]            kind_q;
	logic [TASK_W-1:0]     task_q;
	logic [4:0]            event_q;
	logic [31:0]           dur_q;
	logic [31:0]           now_q;

	logic                  ev_ok_s1;
	logic                  wk_ok_s1;
	logic                  found_s1;
	logic [TASK_W-1:0]     sel_s1;

	logic                  res_status_q;
	logic                  res_disp_q;
	logic [4:0]            res_task_q;
	logic [4:0]            res_event_q;
	logic                  res_noev_q;

	logic                  ev_we;
	logic [TASK_W-1:0]     ev_waddr;
	logic [EVENT_BITS-1:0] ev_wdata;
	logic [TASK_W-1:0]     ev_raddr;
	logic [EVENT_BITS-1:0] ev_rdata;
	logic                  wk_we;
	logic [TASK_W-1:0]     wk_waddr;
	logic [31:0]           wk_wdata;
	logic [TASK_W-1:0]     wk_raddr;
	logic [31:0]           wk_rdata;

	logic                  accept;
	logic                  task_ok;
	logic [7:0]            reg_mask;
	logic                  found_c;
	logic [TASK_W-1:0]     sel_c;
	logic [EVENT_BITS-1:0] mask_rd;
	logic [EVENT_BITS-1:0] ev_bit;
	logic [EVENT_BITS-1:0] mask_post;
	logic [EVENT_BITS-1:0] mask_clr;
	logic [EVENT_BITS-1:0] mask_disp;
	logic [4:0]            low_idx;
	logic [31:0]           wk_rd;
	logic                  out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// mask off slots that do not exist
	always_comb begin
		reg_mask = reg_tasks_q;
		for (int i = 0; i < 8; i++) begin
			if (i >= NUM_TASKS) begin
				reg_mask[i] = 1'b0;
			end
		end
	end

	// check target task and event of post and clear
	assign task_ok = ({1'b0, task_index} < 6'(NUM_TASKS))
		&& reg_mask[task_index[TASK_W-1:0]]
		&& ({1'b0, event_number} < 6'(EVENT_BITS));

	// round-robin search from the scan pointer
	always_comb begin
		logic [TASK_W:0] cand;
		found_c = 1'b0;
		sel_c   = '0;
		for (int i = NUM_TASKS - 1; i >= 0; i--) begin
			cand = {1'b0, scan_q} + (TASK_W + 1)'(i);
			if (cand >= (TASK_W + 1)'(NUM_TASKS)) begin
				cand = cand - (TASK_W + 1)'(NUM_TASKS);
			end
			if (pending_q[cand[TASK_W-1:0]] && reg_mask[cand[TASK_W-1:0]]) begin
				found_c = 1'b1;
				sel_c   = cand[TASK_W-1:0];
			end
		end
	end

	// unwritten entries read as zero
	assign mask_rd = ev_ok_s1 ? ev_rdata : '0;
	assign wk_rd   = wk_ok_s1 ? wk_rdata : '0;

	assign ev_bit    = EVENT_BITS'(1) << event_q;
	assign mask_post = mask_rd | ev_bit;
	assign mask_clr  = mask_rd & ~ev_bit;

	// lowest set event
	always_comb begin
		low_idx = '0;
		for (int i = EVENT_BITS - 1; i >= 0; i--) begin
			if (mask_rd[i]) begin
				low_idx = 5'(i);
			end
		end
	end
	assign mask_disp = mask_rd & ~(EVENT_BITS'(1) << low_idx);

	// RAM ports
	always_comb begin
		ev_raddr = (kind_q == KIND_DISPATCH) ? sel_c : task_q;
		wk_raddr = cnt_q;
		ev_we    = 1'b0;
		ev_waddr = task_q;
		ev_wdata = mask_post;
		wk_we    = 1'b0;
		wk_waddr = running_q;
		wk_wdata = now_q + dur_q;
		case (state_q)
			ST_EXEC: begin
				case (kind_q)
					KIND_POST: begin
						ev_we = 1'b1;
					end
					KIND_CLEAR: begin
						ev_we    = 1'b1;
						ev_wdata = mask_clr;
					end
					KIND_SLEEP: begin
						wk_we = 1'b1;
					end
					KIND_DISPATCH: begin
						ev_we    = found_s1;
						ev_waddr = sel_s1;
						ev_wdata = mask_disp;
					end
					default: begin
						ev_we = 1'b0;
					end
				endcase
			end
			ST_TCMP: begin
				wk_we    = sleeping_q[cnt_q] && (wk_rd == now_q);
				wk_waddr = cnt_q;
				wk_wdata = '0;
			end
			default: begin
				ev_we = 1'b0;
			end
		endcase
	end

	tes_ram #(.DEPTH(NUM_TASKS), .WIDTH(EVENT_BITS)) u_ev_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	tes_ram #(.DEPTH(NUM_TASKS), .WIDTH(32)) u_wk_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.raddr (wk_raddr),
		.rdata (wk_rdata)
	);

	// latch item fields on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			task_q  <= task_index[TASK_W-1:0];
			event_q <= event_number;
			dur_q   <= duration_ms;
			now_q   <= now_ms;
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			reg_tasks_q  <= '0;
			pending_q    <= '0;
			sleeping_q   <= '0;
			ev_vld_q     <= '0;
			wk_vld_q     <= '0;
			scan_q       <= '0;
			running_q    <= '0;
			cnt_q        <= '0;
			ev_ok_s1     <= 1'b0;
			wk_ok_s1     <= 1'b0;
			found_s1     <= 1'b0;
			sel_s1       <= '0;
			res_status_q <= STATUS_OK;
			res_disp_q   <= 1'b0;
			res_task_q   <= '0;
			res_event_q  <= '0;
			res_noev_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				reg_tasks_q <= cfg_wr_data;
			end
			if (ev_we) begin
				ev_vld_q[ev_waddr] <= 1'b1;
			end
			if (wk_we) begin
				wk_vld_q[wk_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_status_q <= STATUS_OK;
						res_disp_q   <= 1'b0;
						res_task_q   <= '0;
						res_event_q  <= '0;
						res_noev_q   <= 1'b0;
						cnt_q        <= '0;
						case (kind)
							KIND_POST, KIND_CLEAR: begin
								if (task_ok) begin
									state_q <= ST_READ;
								end else begin
									res_status_q <= STATUS_ERR;
									state_q      <= ST_PUSH;
								end
							end
							KIND_SLEEP: begin
								state_q <= ST_EXEC;
							end
							KIND_TICK: begin
								state_q <= ST_TRD;
							end
							KIND_DISPATCH: begin
								state_q <= ST_READ;
							end
							default: begin
								res_status_q <= STATUS_ERR;
								state_q      <= ST_PUSH;
							end
						endcase
					end
				end
				ST_READ: begin
					ev_ok_s1 <= ev_vld_q[ev_raddr];
					found_s1 <= found_c;
					sel_s1   <= sel_c;
					state_q  <= ST_EXEC;
				end
				ST_EXEC: begin
					case (kind_q)
						KIND_POST: begin
							pending_q[task_q] <= 1'b1;
						end
						KIND_CLEAR: begin
							if (mask_clr == '0) begin
								pending_q[task_q] <= 1'b0;
							end
						end
						KIND_SLEEP: begin
							sleeping_q[running_q] <= 1'b1;
							pending_q[running_q]  <= 1'b0;
						end
						KIND_DISPATCH: begin
							if (found_s1) begin
								res_disp_q <= 1'b1;
								res_task_q <= 5'(sel_s1);
								running_q  <= sel_s1;
								scan_q     <= ({1'b0, sel_s1} == (TASK_W + 1)'(NUM_TASKS - 1))
									? '0 : TASK_W'({1'b0, sel_s1} + 1'b1);
								if (mask_rd == '0) begin
									res_noev_q <= 1'b1;
								end else begin
									res_event_q <= low_idx;
								end
								if (mask_disp == '0) begin
									pending_q[sel_s1] <= 1'b0;
								end
							end
						end
						default: begin
							res_status_q <= STATUS_ERR;
						end
					endcase
					state_q <= ST_PUSH;
				end
				ST_TRD: begin
					wk_ok_s1 <= wk_vld_q[cnt_q];
					state_q  <= ST_TCMP;
				end
				ST_TCMP: begin
					// wake a sleeper whose time has come
					if (sleeping_q[cnt_q] && (wk_rd == now_q)) begin
						sleeping_q[cnt_q] <= 1'b0;
						pending_q[cnt_q]  <= 1'b1;
					end
					if ({1'b0, cnt_q} == (TASK_W + 1)'(NUM_TASKS - 1)) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_TRD;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			status           <= res_status_q;
			dispatched       <= res_disp_q;
			dispatched_task  <= res_task_q;
			dispatched_event <= res_event_q;
			no_event         <= res_noev_q;
		end
	end

endmodule

// File: rtl/tes_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module tes_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tes_checker.sv
// Port-level checks for the task event scheduler, bound to the top level.
// Depends on task_event_scheduler.
module tes_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       status,
	input logic       dispatched,
	input logic [4:0] dispatched_task,
	input logic [4:0] dispatched_event,
	input logic       no_event
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// zero dispatch fields when nothing was dispatched
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dispatched |->
			dispatched_task == 5'd0 && dispatched_event == 5'd0 && !no_event)
		else $error("dispatch fields set without dispatch");

	// empty mask reports event zero
	a_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_event |-> dispatched && dispatched_event == 5'd0)
		else $error("no_event inconsistent");

	// a dispatch never reports an error
	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dispatched |-> !status)
		else $error("error status on dispatch");

endmodule

bind task_event_scheduler tes_assertions u_tes_assertions (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.status           (status),
	.dispatched       (dispatched),
	.dispatched_task  (dispatched_task),
	.dispatched_event (dispatched_event),
	.no_event         (no_event)
);

// File: bench/tes_checker.sv
// Checker for the task event scheduler: watches the input and result channels,
// predicts each result from its own copy of the scheduler state and compares.
// Depends on tes_pkg.
module tes_checker
	import tes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  task_index,
	input  logic [4:0]  event_number,
	input  logic [31:0] duration_ms,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        status,
	input  logic        dispatched,
	input  logic [4:0]  dispatched_task,
	input  logic [4:0]  dispatched_event,
	input  logic        no_event,
	output int          fail_count,
	output int          pending_results
);

	typedef struct packed {
		logic       status;
		logic       dispatched;
		logic [4:0] dtask;
		logic [4:0] devent;
		logic       no_event;
	} sched_result_t;

	logic [7:0]            reg_tasks;
	logic [7:0]            pend;
	logic [7:0]            sleeping;
	logic [31:0]           masks [NUM_TASKS];
	logic [31:0]           wake [NUM_TASKS];
	logic [TASK_W-1:0]     scan_ptr;
	logic [TASK_W-1:0]     running;
	sched_result_t         expected_results [$];

	assign pending_results = expected_results.size();

	function automatic bit task_usable(logic [4:0] t);
		return (t < NUM_TASKS) && reg_tasks[t[2:0]];
	endfunction

	// advance the predicted state by one item and return its result
	function automatic sched_result_t schedule_item(logic [2:0] k, logic [4:0] t,
			logic [4:0] ev, logic [31:0] dur, logic [31:0] now);
		sched_result_t r;
		logic [TASK_W-1:0] c;
		logic [31:0] m;
		r = '0;
		case (k)
			KIND_POST, KIND_CLEAR: begin
				if (!task_usable(t) || ev >= EVENT_BITS) begin
					r.status = STATUS_ERR;
				end else if (k == KIND_POST) begin
					masks[t[2:0]][ev] = 1'b1;
					pend[t[2:0]] = 1'b1;
				end else begin
					masks[t[2:0]][ev] = 1'b0;
					if (masks[t[2:0]] == 0) pend[t[2:0]] = 1'b0;
				end
			end
			KIND_SLEEP: begin
				wake[running] = now + dur;
				sleeping[running] = 1'b1;
				pend[running] = 1'b0;
			end
			KIND_TICK: begin
				for (int i = 0; i < NUM_TASKS; i++)
					if (sleeping[i] && wake[i] == now) begin
						sleeping[i] = 1'b0;
						pend[i] = 1'b1;
						wake[i] = '0;
					end
			end
			KIND_DISPATCH: begin
				for (int i = 0; i < NUM_TASKS; i++) begin
					c = TASK_W'(scan_ptr + i);
					if (pend[c] && reg_tasks[c]) begin
						m = masks[c];
						r.dispatched = 1'b1;
						r.dtask = 5'(c);
						if (m == 0) begin
							r.no_event = 1'b1;
						end else begin
							for (int b = 31; b >= 0; b--)
								if (m[b]) r.devent = 5'(b);
							m[r.devent] = 1'b0;
						end
						masks[c] = m;
						if (m == 0) pend[c] = 1'b0;
						running = c;
						scan_ptr = c + 1'b1;
						break;
					end
				end
			end
			default: r.status = STATUS_ERR;
		endcase
		return r;
	endfunction

	// predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin
		sched_result_t got, want;
		if (!arst_n) begin
			reg_tasks = '0;
			pend = '0;
			sleeping = '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				masks[i] = '0;
				wake[i] = '0;
			end
			scan_ptr = '0;
			running = '0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) reg_tasks = cfg_wr_data;
			if (out_valid && !out_stall) begin
				got = '{status, dispatched, dispatched_task, dispatched_event, no_event};
				if (expected_results.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", got);
					fail_count = fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected %p, actual %p", want, got);
						fail_count = fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(schedule_item(kind, task_index,
					event_number, duration_ms, now_ms));
		end
	end

endmodule

// File: bench/tb_task_event_scheduler.sv
// Testbench top for the task event scheduler: clock, reset, stimulus with random
// idling on both channels, and the verdict. Depends on tes_pkg, tes_checker, the DUT.
module tb_task_event_scheduler
	import tes_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [4:0]  task_index;
	logic [4:0]  event_number;
	logic [31:0] duration_ms;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic        dispatched;
	logic [4:0]  dispatched_task;
	logic [4:0]  dispatched_event;
	logic        no_event;
	int          fail_count;
	int          pending_results;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;
	int          quiet_cycles;
	logic [31:0] clock_ms;

	task_event_scheduler DUT (.*);
	tes_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// drive receiver stall: random, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one item and hold it until accepted
	task automatic send_item(logic [2:0] k, logic [4:0] t, logic [4:0] ev,
			logic [31:0] dur, logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		task_index <= t;
		event_number <= ev;
		duration_ms <= dur;
		now_ms <= now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drain, then write the task register
	task automatic set_tasks(logic [7:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly well-formed traffic on registered slots
	task automatic random_item();
		int r;
		logic [4:0] t;
		r = $urandom_range(99);
		t = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(NUM_TASKS - 1));
		clock_ms = clock_ms + $urandom_range(3);
		if (r < 30) send_item(KIND_POST, t, 5'($urandom), $urandom, $urandom);
		else if (r < 40) send_item(KIND_CLEAR, t, 5'($urandom), $urandom, $urandom);
		else if (r < 52)
			send_item(KIND_SLEEP, 5'($urandom), 5'($urandom),
				($urandom_range(3) == 0) ? $urandom : $urandom_range(6), clock_ms);
		else if (r < 64)
			send_item(KIND_TICK, 5'($urandom), 5'($urandom), $urandom,
				($urandom_range(9) == 0) ? $urandom : clock_ms);
		else if (r < 97) send_item(KIND_DISPATCH, 5'($urandom), 5'($urandom), $urandom, $urandom);
		else send_item(3'($urandom_range(7, 5)), 5'($urandom), 5'($urandom), $urandom, $urandom);
	endtask

	initial begin
		logic [7:0] settings [4];
		settings = '{8'hff, 8'h00, 8'h5a, 8'h81};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = '0;
		task_index = '0;
		event_number = '0;
		duration_ms = '0;
		now_ms = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		clock_ms = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each kind, error cases, empty mask, wrap of wakeup time
		set_tasks(8'hff);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);
		send_item(KIND_POST, 0, 0, 0, 0);
		send_item(KIND_POST, 7, 31, 0, 0);
		send_item(KIND_POST, 8, 3, 0, 0);
		send_item(KIND_POST, 31, 31, '1, '1);
		send_item(KIND_CLEAR, 20, 1, 0, 0);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);
		send_item(KIND_SLEEP, 0, 0, 32'hffff_ffff, 32'h10);
		send_item(KIND_TICK, 0, 0, 0, 32'h0f);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);
		send_item(KIND_POST, 3, 5, 0, 0);
		send_item(KIND_CLEAR, 3, 5, 0, 0);
		send_item(KIND_CLEAR, 3, 6, 0, 0);
		send_item(3'd5, 0, 0, 0, 0);
		send_item(3'd6, 0, 0, 0, 0);
		send_item(3'd7, 31, 31, '1, '1);
		set_tasks(8'h00);
		send_item(KIND_POST, 2, 2, 0, 0);
		send_item(KIND_DISPATCH, 0, 0, 0, 0);

		// random phases: idling patterns and register settings
		for (int ph = 0; ph < 6; ph++) begin
			set_tasks((ph < 4) ? settings[ph] : 8'($urandom));
			send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 49 : 0;
			recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 23 : 0;
			if (ph == 4) begin
				hold_off <= 1'b1;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off <= 1'b0;
					end
					repeat (40) random_item();
				join
			end
			repeat (200) random_item();
		end
		in_valid <= 1'b0;

		while (pending_results != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tes_pkg.sv
rtl/tes_ram.sv
rtl/task_event_scheduler.sv
rtl/tes_checker.sv
bench/tes_checker.sv
bench/tb_task_event_scheduler.sv
